@@ rtl/tpp_pkg.sv @@
// Shared types and constants for the tracker pattern packer.
// No dependencies; every other file of the block imports this package.
package tpp_pkg;

  localparam int MAX_CHANNELS_DEF     = 4;
  localparam int ROWS_PER_PATTERN_DEF = 64;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [7:0] LAST_FLAG     = 8'h80;
  localparam logic [7:0] NOTE_FLAG     = 8'h40;
  localparam logic [7:0] EFFECT_FLAG   = 8'h20;
  localparam logic [7:0] EFF_REPEAT    = 8'hE0;
  localparam logic [7:0] EFF_LONG      = 8'hF0;
  localparam logic [7:0] EFF_SHORT_LIM = 8'h0E;
  localparam logic [7:0] EMPTY_PATTERN = 8'hC0;

  // one pattern cell; packed order gives note<<12 | effect<<8 | value
  typedef struct packed {
    logic [7:0] note;
    logic [3:0] effect;
    logic [7:0] effect_value;
  } in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       run_last;
    logic       pattern_done;
  } out_t;

  // control part of a row job handed from front to back
  typedef struct packed {
    logic       empty_pat;  // emit the lone empty-pattern byte
    logic       last_row;
    logic       item_end;   // last job caused by its input beat
    logic       pat_end;    // last job of the pattern
    logic [5:0] row_num;
  } job_ctl_t;

endpackage

@@ rtl/tpp_front.sv @@
// Front end of the packer: takes cells, builds rows, holds back the last
// non-empty row and issues row jobs. Depends on tpp_pkg.
module tpp_front #(
  parameter int MAX_CHANNELS     = tpp_pkg::MAX_CHANNELS_DEF,
  parameter int ROWS_PER_PATTERN = tpp_pkg::ROWS_PER_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tpp_pkg::in_t                    in_data,
  input  logic                            cfg_valid,
  input  logic [2:0]                      cfg_data,
  output logic                            push_valid,
  output tpp_pkg::job_ctl_t               push_ctl,
  output tpp_pkg::in_t [MAX_CHANNELS-1:0] push_cells,
  input  logic                            q_full
);
  import tpp_pkg::*;

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [2:0] MaxCnt  = 3'(MAX_CHANNELS);
  localparam logic [6:0] RowsLim = 7'(ROWS_PER_PATTERN);

  logic [2:0]                channels_in_use;
  logic [CW-1:0]             chan_cnt;
  logic [5:0]                row_cnt;
  logic                      held_valid;
  logic [5:0]                held_row;
  in_t  [MAX_CHANNELS-1:0]   cur_cells;
  in_t  [MAX_CHANNELS-1:0]   held_cells;
  logic                      pend_valid;
  job_ctl_t                  pend_ctl;
  in_t  [MAX_CHANNELS-1:0]   pend_cells;

  logic [2:0]                eff_count;
  logic                      accept;
  logic                      row_done;
  logic                      pat_end;
  logic                      nonempty;
  in_t  [MAX_CHANNELS-1:0]   row_cells;
  job_ctl_t                  held_job;
  job_ctl_t                  row_job;

  assign in_stall = pend_valid || q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (channels_in_use == 3'd0) begin
      eff_count = 3'd1;
    end else if (channels_in_use > MaxCnt) begin
      eff_count = MaxCnt;
    end else begin
      eff_count = channels_in_use;
    end
  end

  assign row_done = (4'(chan_cnt) + 4'd1) >= {1'b0, eff_count};
  assign pat_end  = (7'(row_cnt) + 7'd1) >= RowsLim;

  // cells beyond the channel count read as empty; this beat's cell is live
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (3'(c) >= eff_count) begin
        row_cells[c] = '0;
      end else if (CW'(c) == chan_cnt) begin
        row_cells[c] = in_data;
      end else begin
        row_cells[c] = cur_cells[c];
      end
    end
  end

  assign nonempty = |row_cells;

  always_comb begin
    held_job           = '0;
    held_job.row_num   = held_row;
    row_job            = '0;
    row_job.row_num    = row_cnt;
    row_job.last_row   = 1'b1;
    row_job.item_end   = 1'b1;
    row_job.pat_end    = 1'b1;
    push_valid         = 1'b0;
    push_ctl           = held_job;
    push_cells         = held_cells;
    if (pend_valid) begin
      push_valid = !q_full;
      push_ctl   = pend_ctl;
      push_cells = pend_cells;
    end else if (accept && row_done) begin
      if (!pat_end) begin
        push_valid        = nonempty && held_valid;
        push_ctl          = held_job;
        push_ctl.item_end = 1'b1;
      end else if (nonempty) begin
        push_valid = 1'b1;
        if (held_valid) begin
          push_ctl = held_job;
        end else begin
          push_ctl   = row_job;
          push_cells = row_cells;
        end
      end else if (held_valid) begin
        push_valid        = 1'b1;
        push_ctl          = held_job;
        push_ctl.last_row = 1'b1;
        push_ctl.item_end = 1'b1;
        push_ctl.pat_end  = 1'b1;
      end else begin
        push_valid         = 1'b1;
        push_ctl           = row_job;
        push_ctl.empty_pat = 1'b1;
        push_ctl.last_row  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= 3'd4;
      chan_cnt        <= '0;
      row_cnt         <= '0;
      held_valid      <= 1'b0;
      held_row        <= '0;
      pend_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        channels_in_use <= cfg_data;
      end
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        cur_cells[chan_cnt] <= in_data;
        if (!row_done) begin
          chan_cnt <= chan_cnt + 1'b1;
        end else begin
          chan_cnt <= '0;
          if (pat_end) begin
            held_valid <= 1'b0;
            held_row   <= '0;
            row_cnt    <= '0;
            // final row follows the held one from the pending register
            if (nonempty && held_valid) begin
              pend_valid <= 1'b1;
            end
          end else begin
            if (nonempty) begin
              held_cells <= row_cells;
              held_row   <= row_cnt;
              held_valid <= 1'b1;
            end
            row_cnt <= row_cnt + 6'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_done) begin
      pend_ctl   <= row_job;
      pend_cells <= row_cells;
    end
  end

endmodule

@@ rtl/tpp_queue.sv @@
// Short job queue between front and back ends of the packer.
// Register based; depends on tpp_pkg for its depth.
module tpp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         q_valid,
  output logic [W-1:0] q_data
);
  import tpp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] Depth = NW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LastPtr = PW'(QUEUE_DEPTH - 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == Depth);
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/tpp_back.sv @@
// Back end of the packer: serialises a row job into bytes, one byte a cycle
// unless stalled; keeps each channel's previous effect value. Uses tpp_pkg.
module tpp_back #(
  parameter int MAX_CHANNELS = tpp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  tpp_pkg::job_ctl_t               q_ctl,
  input  tpp_pkg::in_t [MAX_CHANNELS-1:0] q_cells,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tpp_pkg::out_t                   out_data
);
  import tpp_pkg::*;

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [2:0] PH_ROW  = 3'd0;
  localparam logic [2:0] PH_CELL = 3'd1;
  localparam logic [2:0] PH_NOTE = 3'd2;
  localparam logic [2:0] PH_EFF  = 3'd3;
  localparam logic [2:0] PH_VAL  = 3'd4;

  logic                    busy;
  job_ctl_t                ctl;
  in_t [MAX_CHANNELS-1:0]  cells;
  logic [CW-1:0]           ch;
  logic [2:0]              phase;
  logic [7:0]              prev [MAX_CHANNELS];

  logic [CW-1:0]           lastch;
  logic                    can;
  in_t                     cur_cell;
  logic                    has_note;
  logic                    has_eff;
  logic                    ch_last;
  logic                    emit;
  logic [7:0]              byte_val;
  logic                    fin;
  logic                    done_cell;
  logic                    skip;
  logic                    upd_prev;
  logic [2:0]              phase_next;

  assign pop = !busy && q_valid;
  assign can = busy && (!out_valid || !out_stall);

  always_comb begin
    lastch = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (cells[c] != '0) begin
        lastch = CW'(c);
      end
    end
  end

  assign cur_cell = cells[ch];
  assign has_note = (cur_cell.note != '0);
  assign has_eff  = (cur_cell.effect != '0) || (cur_cell.effect_value != '0);
  assign ch_last  = (ch == lastch);

  always_comb begin
    emit       = 1'b0;
    byte_val   = '0;
    fin        = 1'b0;
    done_cell  = 1'b0;
    skip       = 1'b0;
    upd_prev   = 1'b0;
    phase_next = phase;
    unique case (phase)
      PH_ROW: begin
        emit = 1'b1;
        if (ctl.empty_pat) begin
          byte_val = EMPTY_PATTERN;
          fin      = 1'b1;
        end else begin
          byte_val   = {ctl.last_row, 1'b0, ctl.row_num};
          phase_next = PH_CELL;
        end
      end
      PH_CELL: begin
        if (cur_cell == '0) begin
          skip = 1'b1;  // empty inner channel, never the last one
        end else begin
          emit     = 1'b1;
          byte_val = 8'(ch) | (ch_last ? LAST_FLAG : 8'h00)
                   | (has_note ? NOTE_FLAG : 8'h00) | (has_eff ? EFFECT_FLAG : 8'h00);
          phase_next = has_note ? PH_NOTE : PH_EFF;
        end
      end
      PH_NOTE: begin
        emit     = 1'b1;
        byte_val = cur_cell.note;
        if (has_eff) begin
          phase_next = PH_EFF;
        end else begin
          done_cell = 1'b1;
        end
      end
      PH_EFF: begin
        emit = 1'b1;
        if (cur_cell.effect_value == prev[ch]) begin
          byte_val  = EFF_REPEAT | {4'h0, cur_cell.effect};
          upd_prev  = 1'b1;
          done_cell = 1'b1;
        end else if (cur_cell.effect_value >= EFF_SHORT_LIM) begin
          byte_val   = EFF_LONG | {4'h0, cur_cell.effect};
          phase_next = PH_VAL;
        end else begin
          byte_val  = {cur_cell.effect_value[3:0], cur_cell.effect};
          upd_prev  = 1'b1;
          done_cell = 1'b1;
        end
      end
      PH_VAL: begin
        emit      = 1'b1;
        byte_val  = cur_cell.effect_value;
        upd_prev  = 1'b1;
        done_cell = 1'b1;
      end
      default: begin
        phase_next = PH_ROW;
      end
    endcase
    if (done_cell) begin
      if (ch_last) begin
        fin = 1'b1;
      end else begin
        phase_next = PH_CELL;
      end
    end
    if (fin) begin
      phase_next = PH_ROW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_ROW;
      ch        <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        prev[c] <= '0;
      end
    end else begin
      if (pop) begin
        ctl   <= q_ctl;
        cells <= q_cells;
        ch    <= '0;
        phase <= PH_ROW;
        busy  <= 1'b1;
      end
      if (can && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (can) begin
        phase <= phase_next;
        if ((done_cell && !ch_last) || skip) begin
          ch <= ch + 1'b1;
        end
        if (fin) begin
          busy <= 1'b0;
        end
        // pattern end clears every channel, so the last update is moot
        if (fin && ctl.pat_end) begin
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            prev[c] <= '0;
          end
        end else if (upd_prev) begin
          prev[ch] <= cur_cell.effect_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can && emit) begin
      out_data.packed_byte  <= byte_val;
      out_data.run_last     <= fin && ctl.item_end;
      out_data.pattern_done <= fin && ctl.pat_end;
    end
  end

endmodule

@@ rtl/tracker_pattern_packer_top.sv @@
// Top level of the tracker pattern packer: front end, job queue, back end.
// Depends on tpp_pkg, tpp_front, tpp_queue and tpp_back.
//
// Cells go in row-major order, one per input beat; the front end takes a
// cell each cycle while the two-entry job queue has room, and a pattern's
// final cell may hold the input while the final row waits in the pending
// register when two rows close at once. The back end writes one byte a
// cycle into an output register while the output is not stalled: a row
// byte, then per non-empty channel a header, a note, an effect and a long
// effect value byte as needed, plus an idle step for each empty channel
// before the last used one. A job is taken from the queue in the cycle
// after the previous one finishes. The empty-pattern byte is 0xC0.
module tracker_pattern_packer_top #(
  parameter int MAX_CHANNELS     = tpp_pkg::MAX_CHANNELS_DEF,
  parameter int ROWS_PER_PATTERN = tpp_pkg::ROWS_PER_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tpp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tpp_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_data
);
  import tpp_pkg::*;

  localparam int CellsW = MAX_CHANNELS * $bits(in_t);
  localparam int JobW   = $bits(job_ctl_t) + CellsW;

  logic                    push_valid;
  job_ctl_t                push_ctl;
  in_t [MAX_CHANNELS-1:0]  push_cells;
  logic                    q_full;
  logic                    q_valid;
  logic [JobW-1:0]         q_data;
  logic                    pop;
  job_ctl_t                q_ctl;
  in_t [MAX_CHANNELS-1:0]  q_cells;

  assign cfg_ready = 1'b1;
  assign q_ctl     = q_data[JobW-1:CellsW];
  assign q_cells   = q_data[CellsW-1:0];

  tpp_front #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .ROWS_PER_PATTERN (ROWS_PER_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ctl   (push_ctl),
    .push_cells (push_cells),
    .q_full     (q_full)
  );

  tpp_queue #(
    .W (JobW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data ({push_ctl, push_cells}),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  tpp_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_cells   (q_cells),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/tpp_checker.sv @@
// Port-level checks for the tracker pattern packer, bound to the top level.
// Depends on tpp_pkg and tracker_pattern_packer_top.
module tpp_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input tpp_pkg::out_t out_data
);
  import tpp_pkg::*;

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // the pattern's final byte is always the last byte of its input beat
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pattern_done |-> out_data.run_last)
    else $error("pattern_done without run_last");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind tracker_pattern_packer_top tpp_checker u_tpp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
